### rtl/core/twbm_pkg.sv
`timescale 1ns / 1ps

package twbm_pkg;

	// Word and field widths
	localparam int WORD_W     = 32;
	localparam int PERIOD_W   = 16;
	localparam int COUNT_W    = 6;
	localparam int REQ_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Defaults
	localparam int MAX_BITS_DEF = 32;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 6'd8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DRAIN = 2'd2;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_START     = 4'd0,
		REQ_STOP      = 4'd1,
		REQ_WRITE     = 4'd2,
		REQ_READ      = 4'd3,
		REQ_CLK_HIGH  = 4'd4,
		REQ_CLK_LOW   = 4'd5,
		REQ_DATA_HIGH = 4'd6,
		REQ_DATA_LOW  = 4'd7,
		REQ_SAMPLE    = 4'd8,
		REQ_PULSE     = 4'd9,
		REQ_BIT_READ  = 4'd10
	} req_t;

	// Controller states; each non-idle state emits one pin phase
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_A,
		ST_START_B,
		ST_START_C,
		ST_STOP_A,
		ST_STOP_B,
		ST_WR_LOW,
		ST_WR_HIGH,
		ST_RD_LOW,
		ST_RD_HIGH,
		ST_SINGLE,
		ST_PULSE_A,
		ST_PULSE_B,
		ST_PULSE_C
	} state_t;

	typedef struct packed {
		logic   idle;
		logic   load;
		logic   emit;
		state_t phase;
	} twbm_cmd_t;

	typedef struct packed {
		logic             req_valid;
		logic [REQ_W-1:0] req_type;
		logic             out_free;
		logic             bit_zero;
	} twbm_status_t;

endpackage

### rtl/core/twbm_req_if.sv
`timescale 1ns / 1ps

interface twbm_req_if;
	logic                         valid;
	logic                         ready;
	logic [twbm_pkg::REQ_W-1:0]  req_type;
	logic [twbm_pkg::WORD_W-1:0] write_value;
	logic [twbm_pkg::WORD_W-1:0] line_bits;

	modport source (output valid, req_type, write_value, line_bits, input ready);
	modport sink   (input valid, req_type, write_value, line_bits, output ready);
endinterface

### rtl/core/twbm_phase_if.sv
`timescale 1ns / 1ps

interface twbm_phase_if;
	logic                           valid;
	logic                           ready;
	logic                           clk_level;
	logic                           data_level;
	logic                           data_drive;
	logic [twbm_pkg::PERIOD_W-1:0] hold_us;
	logic [twbm_pkg::WORD_W-1:0]   read_value;
	logic                           read_valid;
	logic                           last;

	modport source (output valid, clk_level, data_level, data_drive, hold_us, read_value,
		read_valid, last, input ready);
	modport sink   (input valid, clk_level, data_level, data_drive, hold_us, read_value,
		read_valid, last, output ready);
endinterface

### rtl/core/twbm_cfg_if.sv
`timescale 1ns / 1ps

interface twbm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [twbm_pkg::CFG_IDX_W-1:0]  index;
	logic [twbm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/twbm_ctrl.sv
`timescale 1ns / 1ps

module twbm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  twbm_pkg::twbm_status_t status,
	output twbm_pkg::twbm_cmd_t    cmd
);

	twbm_pkg::state_t state_q, state_d;
	logic             idle;
	logic             emit;

	assign idle = (state_q == twbm_pkg::ST_IDLE);
	assign emit = !idle && status.out_free;

	// Hold the current phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance one phase per transfer into the output register
	always_comb begin
		state_d = state_q;
		case (state_q)
			twbm_pkg::ST_IDLE: begin
				if (status.req_valid) begin
					case (status.req_type)
						twbm_pkg::REQ_START:     state_d = twbm_pkg::ST_START_A;
						twbm_pkg::REQ_STOP:      state_d = twbm_pkg::ST_STOP_A;
						twbm_pkg::REQ_WRITE:     state_d = twbm_pkg::ST_WR_LOW;
						twbm_pkg::REQ_READ:      state_d = twbm_pkg::ST_RD_LOW;
						twbm_pkg::REQ_CLK_HIGH,
						twbm_pkg::REQ_CLK_LOW,
						twbm_pkg::REQ_DATA_HIGH,
						twbm_pkg::REQ_DATA_LOW,
						twbm_pkg::REQ_SAMPLE:    state_d = twbm_pkg::ST_SINGLE;
						twbm_pkg::REQ_PULSE,
						twbm_pkg::REQ_BIT_READ:  state_d = twbm_pkg::ST_PULSE_A;
						default:                 state_d = twbm_pkg::ST_IDLE;
					endcase
				end
			end
			twbm_pkg::ST_START_A: if (emit) state_d = twbm_pkg::ST_START_B;
			twbm_pkg::ST_START_B: if (emit) state_d = twbm_pkg::ST_START_C;
			twbm_pkg::ST_START_C: if (emit) state_d = twbm_pkg::ST_IDLE;
			twbm_pkg::ST_STOP_A:  if (emit) state_d = twbm_pkg::ST_STOP_B;
			twbm_pkg::ST_STOP_B:  if (emit) state_d = twbm_pkg::ST_IDLE;
			twbm_pkg::ST_WR_LOW:  if (emit) state_d = twbm_pkg::ST_WR_HIGH;
			twbm_pkg::ST_WR_HIGH: begin
				if (emit) state_d = status.bit_zero ? twbm_pkg::ST_IDLE : twbm_pkg::ST_WR_LOW;
			end
			twbm_pkg::ST_RD_LOW:  if (emit) state_d = twbm_pkg::ST_RD_HIGH;
			twbm_pkg::ST_RD_HIGH: begin
				if (emit) state_d = status.bit_zero ? twbm_pkg::ST_IDLE : twbm_pkg::ST_RD_LOW;
			end
			twbm_pkg::ST_SINGLE:  if (emit) state_d = twbm_pkg::ST_IDLE;
			twbm_pkg::ST_PULSE_A: if (emit) state_d = twbm_pkg::ST_PULSE_B;
			twbm_pkg::ST_PULSE_B: if (emit) state_d = twbm_pkg::ST_PULSE_C;
			twbm_pkg::ST_PULSE_C: if (emit) state_d = twbm_pkg::ST_IDLE;
			default:              state_d = twbm_pkg::ST_IDLE;
		endcase
	end

	// Drive commands to the datapath
	always_comb begin
		cmd.idle  = idle;
		cmd.load  = idle && status.req_valid;
		cmd.emit  = emit;
		cmd.phase = state_q;
	end

endmodule

### rtl/core/twbm_dp.sv
`timescale 1ns / 1ps

module twbm_dp #(
	parameter int MAX_BITS = twbm_pkg::MAX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	twbm_req_if.sink               req,
	twbm_phase_if.source           phase,
	twbm_cfg_if.sink               cfg,
	input  twbm_pkg::twbm_cmd_t    cmd,
	output twbm_pkg::twbm_status_t status
);

	localparam int IDX_W = $clog2(twbm_pkg::WORD_W);
	localparam logic [twbm_pkg::COUNT_W-1:0] MAX_N = twbm_pkg::COUNT_W'(MAX_BITS);
	localparam logic [twbm_pkg::WORD_W-1:0]  ALL_ONES = '1;

	// Configuration registers
	logic [twbm_pkg::PERIOD_W-1:0] period_q;
	logic [twbm_pkg::COUNT_W-1:0]  bit_count_q;

	// Bus state and per-request latches
	logic                          clock_now_q;
	logic                          data_now_q;
	logic                          drive_now_q;
	logic                          clk_first_q;
	logic                          has_result_q;
	logic [IDX_W-1:0]              idx_q;
	logic [twbm_pkg::WORD_W-1:0]   wv_q;
	logic [twbm_pkg::WORD_W-1:0]   rv_q;

	// Output register
	logic                          out_valid_q;
	logic                          out_clk_q;
	logic                          out_dl_q;
	logic                          out_dr_q;
	logic [twbm_pkg::PERIOD_W-1:0] out_hold_q;
	logic [twbm_pkg::WORD_W-1:0]   out_rv_q;
	logic                          out_rvld_q;
	logic                          out_last_q;

	logic [twbm_pkg::COUNT_W-1:0]  n_eff;
	logic [twbm_pkg::PERIOD_W-1:0] half;
	logic [twbm_pkg::WORD_W-1:0]   read_mask;
	logic                          wbit;
	logic                          bit_zero;
	logic                          out_free;
	logic                          ph_clk;
	logic                          ph_dat;
	logic                          ph_drv;
	logic [twbm_pkg::PERIOD_W-1:0] ph_hold;
	logic                          ph_rvld;
	logic                          ph_last;

	assign cfg.ready = 1'b1;
	assign req.ready = cmd.idle;

	// Clamp the word length into 1..MAX_BITS
	always_comb begin
		if (bit_count_q == '0) begin
			n_eff = twbm_pkg::COUNT_W'(1);
		end else if (bit_count_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = bit_count_q;
		end
	end

	assign read_mask = ALL_ONES >> (7'(twbm_pkg::WORD_W) - 7'(n_eff));
	assign half      = period_q >> 1;
	assign wbit      = wv_q[idx_q];
	assign bit_zero  = (idx_q == '0);
	assign out_free  = !out_valid_q || phase.ready;

	always_comb begin
		status.req_valid = req.valid;
		status.req_type  = req.req_type;
		status.out_free  = out_free;
		status.bit_zero  = bit_zero;
	end

	// Write configuration registers; a pad type write is accepted but not stored here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= twbm_pkg::PERIOD_RST;
			bit_count_q <= twbm_pkg::COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				twbm_pkg::CFG_PERIOD:     period_q <= cfg.data;
				twbm_pkg::CFG_BIT_COUNT:  bit_count_q <= cfg.data[twbm_pkg::COUNT_W-1:0];
				twbm_pkg::CFG_OPEN_DRAIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Update bus state at request transfer to its value after the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_now_q <= 1'b0;
			data_now_q  <= 1'b1;
			drive_now_q <= 1'b0;
		end else if (cmd.load) begin
			case (req.req_type)
				twbm_pkg::REQ_START: begin
					clock_now_q <= 1'b0;
					data_now_q  <= 1'b0;
					drive_now_q <= 1'b1;
				end
				twbm_pkg::REQ_STOP: begin
					clock_now_q <= 1'b1;
					data_now_q  <= 1'b1;
					drive_now_q <= 1'b1;
				end
				twbm_pkg::REQ_WRITE: begin
					clock_now_q <= 1'b0;
					data_now_q  <= req.write_value[0];
					drive_now_q <= 1'b1;
				end
				twbm_pkg::REQ_READ: begin
					clock_now_q <= 1'b0;
					drive_now_q <= 1'b0;
				end
				twbm_pkg::REQ_CLK_HIGH:  clock_now_q <= 1'b1;
				twbm_pkg::REQ_CLK_LOW:   clock_now_q <= 1'b0;
				twbm_pkg::REQ_DATA_HIGH: begin
					data_now_q  <= 1'b1;
					drive_now_q <= 1'b1;
				end
				twbm_pkg::REQ_DATA_LOW: begin
					data_now_q  <= 1'b0;
					drive_now_q <= 1'b1;
				end
				twbm_pkg::REQ_SAMPLE:    drive_now_q <= 1'b0;
				twbm_pkg::REQ_PULSE:     clock_now_q <= 1'b0;
				twbm_pkg::REQ_BIT_READ: begin
					clock_now_q <= 1'b0;
					drive_now_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Latch the request payload and step the bit index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wv_q         <= req.write_value;
			clk_first_q  <= clock_now_q;
			idx_q        <= IDX_W'(n_eff - twbm_pkg::COUNT_W'(1));
			has_result_q <= (req.req_type == twbm_pkg::REQ_READ) ||
				(req.req_type == twbm_pkg::REQ_SAMPLE) ||
				(req.req_type == twbm_pkg::REQ_BIT_READ);
			if (req.req_type == twbm_pkg::REQ_READ) begin
				rv_q <= req.line_bits & read_mask;
			end else begin
				rv_q <= {{(twbm_pkg::WORD_W-1){1'b0}}, req.line_bits[0]};
			end
		end else if (cmd.emit && ((cmd.phase == twbm_pkg::ST_WR_HIGH) ||
				(cmd.phase == twbm_pkg::ST_RD_HIGH)) && !bit_zero) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	// Form the pin phase for the current state
	always_comb begin
		ph_clk  = 1'b0;
		ph_dat  = 1'b0;
		ph_drv  = 1'b0;
		ph_hold = '0;
		ph_rvld = 1'b0;
		ph_last = 1'b0;
		case (cmd.phase)
			twbm_pkg::ST_START_A: begin
				ph_clk = 1'b1; ph_dat = 1'b1; ph_drv = 1'b1; ph_hold = half;
			end
			twbm_pkg::ST_START_B: begin
				ph_clk = 1'b1; ph_drv = 1'b1; ph_hold = half;
			end
			twbm_pkg::ST_START_C: begin
				ph_drv = 1'b1; ph_last = 1'b1;
			end
			twbm_pkg::ST_STOP_A: begin
				ph_clk = 1'b1; ph_drv = 1'b1; ph_hold = half;
			end
			twbm_pkg::ST_STOP_B: begin
				ph_clk = 1'b1; ph_dat = 1'b1; ph_drv = 1'b1; ph_hold = half; ph_last = 1'b1;
			end
			twbm_pkg::ST_WR_LOW: begin
				ph_dat = wbit; ph_drv = 1'b1; ph_hold = half;
			end
			twbm_pkg::ST_WR_HIGH: begin
				ph_clk = 1'b1; ph_dat = wbit; ph_drv = 1'b1; ph_hold = half;
				ph_last = bit_zero;
			end
			twbm_pkg::ST_RD_LOW: begin
				ph_hold = half;
			end
			twbm_pkg::ST_RD_HIGH: begin
				ph_clk = 1'b1; ph_hold = half; ph_last = bit_zero; ph_rvld = bit_zero;
			end
			twbm_pkg::ST_SINGLE: begin
				ph_clk  = clock_now_q;
				ph_dat  = data_now_q;
				ph_drv  = drive_now_q;
				ph_last = 1'b1;
				ph_rvld = has_result_q;
			end
			twbm_pkg::ST_PULSE_A: begin
				ph_clk  = clk_first_q;
				ph_dat  = data_now_q;
				ph_drv  = drive_now_q;
				ph_hold = period_q;
			end
			twbm_pkg::ST_PULSE_B: begin
				ph_clk  = 1'b1;
				ph_dat  = data_now_q;
				ph_drv  = drive_now_q;
				ph_hold = half;
			end
			twbm_pkg::ST_PULSE_C: begin
				ph_dat  = data_now_q;
				ph_drv  = drive_now_q;
				ph_hold = period_q;
				ph_last = 1'b1;
				ph_rvld = has_result_q;
			end
			default: begin
			end
		endcase
	end

	// Hold the phase until it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (phase.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_clk_q  <= ph_clk;
			out_dl_q   <= ph_dat && ph_drv;
			out_dr_q   <= ph_drv;
			out_hold_q <= ph_hold;
			out_rv_q   <= ph_rvld ? rv_q : '0;
			out_rvld_q <= ph_rvld;
			out_last_q <= ph_last;
		end
	end

	assign phase.valid      = out_valid_q;
	assign phase.clk_level  = out_clk_q;
	assign phase.data_level = out_dl_q;
	assign phase.data_drive = out_dr_q;
	assign phase.hold_us    = out_hold_q;
	assign phase.read_value = out_rv_q;
	assign phase.read_valid = out_rvld_q;
	assign phase.last       = out_last_q;

endmodule

### rtl/core/two_wire_bit_master.sv
// Flow: a request transfers while the controller is idle; its first pin phase passes
// the state register, then the output register; later phases load as the output frees.
// Throughput: one phase per cycle while the sink holds ready, set by the controller
// stepping one phase per state; the next request waits until the last phase is loaded.
// Reset: clock low, data released high and undriven, period 1000 us, 8 bits per word.
`timescale 1ns / 1ps

module two_wire_bit_master #(
	parameter int MAX_BITS = twbm_pkg::MAX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	twbm_req_if.sink     req,
	twbm_phase_if.source phase,
	twbm_cfg_if.sink     cfg
);

	twbm_pkg::twbm_cmd_t    cmd;
	twbm_pkg::twbm_status_t status;

	twbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	twbm_dp #(
		.MAX_BITS (MAX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.phase  (phase),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule

### tb/two_wire_bit_master_tb.sv
`timescale 1ns / 1ps

module two_wire_bit_master_tb;

	localparam int WORD_LIMIT = twbm_pkg::MAX_BITS_DEF;
	localparam int FIELD_W = twbm_pkg::WORD_W;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ROUNDS = 6;
	localparam int ROUND_ITEMS = 18;
	localparam logic [twbm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [twbm_pkg::REQ_W-1:0] REQ_UNKNOWN_LO = 4'd11;
	localparam logic [twbm_pkg::REQ_W-1:0] REQ_UNKNOWN_HI = 4'd15;

	typedef struct {
		logic [twbm_pkg::REQ_W-1:0]  kind;
		logic [twbm_pkg::WORD_W-1:0] write_value;
		logic [twbm_pkg::WORD_W-1:0] line_bits;
	} bus_req_t;

	typedef struct {
		logic                          clk_level;
		logic                          data_level;
		logic                          data_drive;
		logic [twbm_pkg::PERIOD_W-1:0] hold_us;
		logic [twbm_pkg::WORD_W-1:0]   read_value;
		logic                          read_valid;
		logic                          last;
	} pin_phase_t;

	logic clk;
	logic arst_n;

	twbm_req_if   req_bus ();
	twbm_phase_if phase_bus ();
	twbm_cfg_if   cfg_bus ();

	two_wire_bit_master dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.phase  (phase_bus),
		.cfg    (cfg_bus)
	);

	// Requests waiting for the driver; the front one is on the bus
	bus_req_t   req_backlog[$];
	pin_phase_t expected_phases[$];

	// Bus state and register copies
	logic                          bus_clk;
	logic                          bus_data;
	logic                          bus_drive;
	logic [twbm_pkg::PERIOD_W-1:0] period_reg;
	logic [twbm_pkg::COUNT_W-1:0]  count_reg;

	int errors;
	int src_gap_pct;
	int snk_stall_pct;
	int gap_left;
	int stall_left;
	logic drain_hold;

	always #2 clk = ~clk;

	function automatic void push_phase(logic c, logic d, logic drv,
		logic [twbm_pkg::PERIOD_W-1:0] hold, logic [twbm_pkg::WORD_W-1:0] rv, logic rvld,
		logic fin);
		pin_phase_t p;
		p.clk_level  = c;
		p.data_level = drv ? d : 1'b0;
		p.data_drive = drv;
		p.hold_us    = hold;
		p.read_value = rv;
		p.read_valid = rvld;
		p.last       = fin;
		expected_phases.push_back(p);
	endfunction

	// Expand one request into its pin phases and advance the bus state
	function automatic void predict_pin_phases(logic [twbm_pkg::REQ_W-1:0] kind,
		logic [twbm_pkg::WORD_W-1:0] wv, logic [twbm_pkg::WORD_W-1:0] lb);
		logic [twbm_pkg::PERIOD_W-1:0] half;
		logic [twbm_pkg::PERIOD_W-1:0] full;
		logic [twbm_pkg::WORD_W-1:0]   rv;
		logic                          b;
		int                            n;
		half = period_reg >> 1;
		full = period_reg;
		n = (count_reg == 0) ? 1 : ((count_reg > WORD_LIMIT) ? WORD_LIMIT : int'(count_reg));
		case (kind)
			twbm_pkg::REQ_START: begin
				push_phase(1'b1, 1'b1, 1'b1, half, '0, 1'b0, 1'b0);
				push_phase(1'b1, 1'b0, 1'b1, half, '0, 1'b0, 1'b0);
				push_phase(1'b0, 1'b0, 1'b1, '0, '0, 1'b0, 1'b1);
				bus_clk = 1'b0; bus_data = 1'b0; bus_drive = 1'b1;
			end
			twbm_pkg::REQ_STOP: begin
				push_phase(1'b1, 1'b0, 1'b1, half, '0, 1'b0, 1'b0);
				push_phase(1'b1, 1'b1, 1'b1, half, '0, 1'b0, 1'b1);
				bus_clk = 1'b1; bus_data = 1'b1; bus_drive = 1'b1;
			end
			twbm_pkg::REQ_WRITE: begin
				b = bus_data;
				for (int i = 0; i < n; i++) begin
					b = wv[n-1-i];
					push_phase(1'b0, b, 1'b1, half, '0, 1'b0, 1'b0);
					push_phase(1'b1, b, 1'b1, half, '0, 1'b0, i + 1 == n);
				end
				// clock drops at the end of the word without a phase of its own
				bus_clk = 1'b0; bus_data = b; bus_drive = 1'b1;
			end
			twbm_pkg::REQ_READ: begin
				rv = (n == twbm_pkg::WORD_W) ? lb : (lb & ((32'd1 << n) - 32'd1));
				for (int i = 0; i < n; i++) begin
					push_phase(1'b0, 1'b0, 1'b0, half, '0, 1'b0, 1'b0);
					if (i + 1 == n)
						push_phase(1'b1, 1'b0, 1'b0, half, rv, 1'b1, 1'b1);
					else
						push_phase(1'b1, 1'b0, 1'b0, half, '0, 1'b0, 1'b0);
				end
				bus_clk = 1'b0; bus_drive = 1'b0;
			end
			twbm_pkg::REQ_CLK_HIGH, twbm_pkg::REQ_CLK_LOW: begin
				bus_clk = (kind == twbm_pkg::REQ_CLK_HIGH);
				push_phase(bus_clk, bus_data, bus_drive, '0, '0, 1'b0, 1'b1);
			end
			twbm_pkg::REQ_DATA_HIGH, twbm_pkg::REQ_DATA_LOW: begin
				bus_data = (kind == twbm_pkg::REQ_DATA_HIGH);
				bus_drive = 1'b1;
				push_phase(bus_clk, bus_data, 1'b1, '0, '0, 1'b0, 1'b1);
			end
			twbm_pkg::REQ_SAMPLE: begin
				bus_drive = 1'b0;
				push_phase(bus_clk, 1'b0, 1'b0, '0, {31'd0, lb[0]}, 1'b1, 1'b1);
			end
			twbm_pkg::REQ_PULSE: begin
				push_phase(bus_clk, bus_data, bus_drive, full, '0, 1'b0, 1'b0);
				push_phase(1'b1, bus_data, bus_drive, half, '0, 1'b0, 1'b0);
				push_phase(1'b0, bus_data, bus_drive, full, '0, 1'b0, 1'b1);
				bus_clk = 1'b0;
			end
			twbm_pkg::REQ_BIT_READ: begin
				bus_drive = 1'b0;
				push_phase(bus_clk, 1'b0, 1'b0, full, '0, 1'b0, 1'b0);
				push_phase(1'b1, 1'b0, 1'b0, half, '0, 1'b0, 1'b0);
				push_phase(1'b0, 1'b0, 1'b0, full, {31'd0, lb[0]}, 1'b1, 1'b1);
				bus_clk = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [FIELD_W-1:0] exp_v,
		logic [FIELD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Compare one transferred phase with the oldest expectation
	function automatic void compare_phase();
		pin_phase_t e;
		if (expected_phases.size() == 0) begin
			$error("phase transferred with nothing expected");
			errors++;
		end else begin
			e = expected_phases.pop_front();
			check_field("clk_level", FIELD_W'(e.clk_level), FIELD_W'(phase_bus.clk_level));
			check_field("data_level", FIELD_W'(e.data_level), FIELD_W'(phase_bus.data_level));
			check_field("data_drive", FIELD_W'(e.data_drive), FIELD_W'(phase_bus.data_drive));
			check_field("hold_us", FIELD_W'(e.hold_us), FIELD_W'(phase_bus.hold_us));
			check_field("read_value", e.read_value, phase_bus.read_value);
			check_field("read_valid", FIELD_W'(e.read_valid), FIELD_W'(phase_bus.read_valid));
			check_field("last", FIELD_W'(e.last), FIELD_W'(phase_bus.last));
		end
	endfunction

	// Request driver: present the backlog front, pop it on transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			gap_left <= 0;
			drain_hold <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				predict_pin_phases(req_backlog[0].kind, req_backlog[0].write_value,
					req_backlog[0].line_bits);
				void'(req_backlog.pop_front());
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_bus.valid <= 1'b0;
				end else if (drain_hold && expected_phases.size() != 0) begin
					req_bus.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					req_bus.valid       <= 1'b1;
					req_bus.req_type    <= req_backlog[0].kind;
					req_bus.write_value <= req_backlog[0].write_value;
					req_bus.line_bits   <= req_backlog[0].line_bits;
					if ($urandom_range(99) < src_gap_pct)
						gap_left <= $urandom_range(1, 6);
					drain_hold <= ($urandom_range(39) == 0);
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Phase monitor: check transfers, stall in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			phase_bus.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (phase_bus.valid && phase_bus.ready)
				compare_phase();
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				phase_bus.ready <= 1'b0;
			end else if ($urandom_range(99) < snk_stall_pct) begin
				stall_left <= $urandom_range(0, 5);
				phase_bus.ready <= 1'b0;
			end else begin
				phase_bus.ready <= 1'b1;
			end
		end
	end

	// End the run when no transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (phase_bus.valid && phase_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic queue_item(logic [twbm_pkg::REQ_W-1:0] kind,
		logic [twbm_pkg::WORD_W-1:0] wv, logic [twbm_pkg::WORD_W-1:0] lb);
		bus_req_t r;
		r.kind = kind;
		r.write_value = wv;
		r.line_bits = lb;
		req_backlog.push_back(r);
	endtask

	task automatic cfg_write(logic [twbm_pkg::CFG_IDX_W-1:0] idx,
		logic [twbm_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			twbm_pkg::CFG_PERIOD:     period_reg = value;
			twbm_pkg::CFG_BIT_COUNT:  count_reg = value[twbm_pkg::COUNT_W-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	// Wait until every request has transferred and every phase has come back
	task automatic settle();
		while (req_backlog.size() != 0 || req_bus.valid || expected_phases.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly framed transactions with random content, some loose requests
	task automatic queue_random_round(int count);
		int added;
		int words;
		logic [twbm_pkg::REQ_W-1:0] kind;
		added = 0;
		while (added < count) begin
			if ($urandom_range(99) < 70) begin
				queue_item(twbm_pkg::REQ_START, $urandom, $urandom);
				words = $urandom_range(1, 3);
				for (int w = 0; w < words; w++)
					queue_item($urandom_range(0, 1) ? twbm_pkg::REQ_WRITE : twbm_pkg::REQ_READ,
						$urandom, $urandom);
				queue_item(twbm_pkg::REQ_STOP, $urandom, $urandom);
				added += words + 2;
			end else begin
				kind = twbm_pkg::REQ_W'($urandom_range(0, 15));
				queue_item(kind, $urandom, $urandom);
				if (kind <= twbm_pkg::REQ_BIT_READ)
					added++;
			end
		end
	endtask

	task automatic random_config();
		logic [twbm_pkg::CFG_DATA_W-1:0] per;
		logic [twbm_pkg::COUNT_W-1:0]    cnt;
		int pick;
		pick = $urandom_range(9);
		per = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF :
			16'($urandom_range(2, 65535));
		pick = $urandom_range(9);
		cnt = (pick == 0) ? 6'd0 : (pick == 1) ? 6'($urandom_range(33, 63)) :
			(pick == 2) ? 6'd32 : 6'($urandom_range(1, 8));
		cfg_write(twbm_pkg::CFG_PERIOD, per);
		cfg_write(twbm_pkg::CFG_BIT_COUNT, {10'($urandom), cnt});
		cfg_write(twbm_pkg::CFG_OPEN_DRAIN, 16'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		src_gap_pct = 25;
		snk_stall_pct = 25;
		req_bus.valid = 1'b0;
		req_bus.req_type = '0;
		req_bus.write_value = '0;
		req_bus.line_bits = '0;
		phase_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		bus_clk = 1'b0;
		bus_data = 1'b1;
		bus_drive = 1'b0;
		period_reg = twbm_pkg::PERIOD_RST;
		count_reg = twbm_pkg::COUNT_RST;
		gap_left = 0;
		stall_left = 0;
		drain_hold = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every request kind at the reset settings, plus unknown codes
		queue_item(twbm_pkg::REQ_START, '0, '0);
		queue_item(twbm_pkg::REQ_WRITE, 32'h0000_00A5, '0);
		queue_item(twbm_pkg::REQ_READ, '0, $urandom);
		queue_item(twbm_pkg::REQ_STOP, '0, '0);
		queue_item(twbm_pkg::REQ_CLK_HIGH, '0, '0);
		queue_item(twbm_pkg::REQ_CLK_LOW, '0, '0);
		queue_item(twbm_pkg::REQ_DATA_HIGH, '0, '0);
		queue_item(twbm_pkg::REQ_DATA_LOW, '0, '0);
		queue_item(twbm_pkg::REQ_SAMPLE, '0, 32'h0000_0001);
		queue_item(twbm_pkg::REQ_SAMPLE, '0, 32'hFFFF_FFFE);
		queue_item(twbm_pkg::REQ_PULSE, '0, '0);
		queue_item(twbm_pkg::REQ_BIT_READ, '0, 32'h0000_0001);
		queue_item(REQ_UNKNOWN_LO, $urandom, $urandom);
		queue_item(REQ_UNKNOWN_HI, $urandom, $urandom);
		settle();

		// Longest period and widest word
		cfg_write(twbm_pkg::CFG_PERIOD, 16'hFFFF);
		cfg_write(twbm_pkg::CFG_BIT_COUNT, 16'd32);
		cfg_write(twbm_pkg::CFG_OPEN_DRAIN, 16'd1);
		cfg_write(CFG_UNUSED, 16'hFFFF);
		queue_item(twbm_pkg::REQ_WRITE, 32'hFFFF_FFFF, '0);
		queue_item(twbm_pkg::REQ_READ, '0, 32'hFFFF_FFFF);
		queue_item(twbm_pkg::REQ_WRITE, 32'h0000_0000, '0);
		queue_item(twbm_pkg::REQ_READ, '0, 32'h0000_0000);
		settle();

		// Zero word length counts as one bit, zero period
		cfg_write(twbm_pkg::CFG_PERIOD, 16'd0);
		cfg_write(twbm_pkg::CFG_BIT_COUNT, 16'hFFC0);
		cfg_write(twbm_pkg::CFG_OPEN_DRAIN, 16'd0);
		queue_item(twbm_pkg::REQ_WRITE, 32'h0000_0001, '0);
		queue_item(twbm_pkg::REQ_READ, '0, 32'hFFFF_FFFF);
		queue_item(twbm_pkg::REQ_PULSE, '0, '0);
		queue_item(twbm_pkg::REQ_BIT_READ, '0, 32'h0000_0000);
		settle();

		// Oversized word length clamps to the maximum, period of one
		cfg_write(twbm_pkg::CFG_PERIOD, 16'd1);
		cfg_write(twbm_pkg::CFG_BIT_COUNT, 16'd63);
		queue_item(twbm_pkg::REQ_READ, '0, $urandom);
		queue_item(twbm_pkg::REQ_WRITE, $urandom, '0);
		settle();

		// Random rounds; one with no idling midway and none in the last
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			if (round == 2 || round == RANDOM_ROUNDS - 1) begin
				src_gap_pct = 0;
				snk_stall_pct = 0;
			end else begin
				src_gap_pct = $urandom_range(10, 50);
				snk_stall_pct = $urandom_range(10, 50);
			end
			if (round == 0) begin
				cfg_write(twbm_pkg::CFG_PERIOD, 16'd2);
				cfg_write(twbm_pkg::CFG_BIT_COUNT, 16'd1);
				cfg_write(twbm_pkg::CFG_OPEN_DRAIN, 16'd1);
			end else begin
				random_config();
			end
			queue_random_round(ROUND_ITEMS);
			settle();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
